@@ rtl/r2a_pkg.sv @@
// Shared types, constants and the digit-to-character function of the radix converter.
package r2a_pkg;

	localparam int unsigned BASE_W    = 6;
	localparam int unsigned DIGIT_W   = 6;
	localparam int unsigned CHAR_W    = 7;
	localparam int unsigned RAW_W     = 64;
	localparam int unsigned DEC_DIGITS = 10;

	localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);  // '0'
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(97);  // 'a'
	localparam logic [CHAR_W-1:0] CHAR_NONE  = CHAR_W'(0);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT,
		ST_BAD
	} state_t;

	// Controls from the sequencer to the digit array.
	typedef struct packed {
		logic clear;  // zero all cells for a new request
		logic feed;   // push one value bit into the lowest cell
		logic shift;  // move every digit one cell toward the top
	} ctrl_t;

	// Map a digit 0..35 to '0'-'9' or 'a'-'z'.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] d7;
		d7 = CHAR_W'(d);
		if (d7 < CHAR_W'(DEC_DIGITS))
			return CHAR_ZERO + d7;
		else
			return CHAR_ALPHA + d7 - CHAR_W'(DEC_DIGITS);
	endfunction

endpackage

@@ rtl/r2a_in_if.sv @@
// Request channel: value and base with valid/ready handshake.
interface r2a_in_if;
	logic                            valid;
	logic                            ready;
	logic [r2a_pkg::RAW_W-1:0]       value;
	logic [r2a_pkg::BASE_W-1:0]      base;

	modport source (output valid, output value, output base, input ready);
	modport sink   (input valid, input value, input base, output ready);
endinterface

@@ rtl/r2a_out_if.sv @@
// Result channel: one ASCII digit per transfer with last and invalid-base flags.
interface r2a_out_if;
	logic                            valid;
	logic                            ready;
	logic [r2a_pkg::CHAR_W-1:0]      digit_char;
	logic                            last;
	logic                            invalid_base;

	modport source (output valid, output digit_char, output last, output invalid_base,
		input ready);
	modport sink   (input valid, input digit_char, input last, input invalid_base,
		output ready);
endinterface

@@ rtl/r2a_digit_array.sv @@
// Systolic row of base-b digit cells: doubles and adds one bit per step, then shifts out.
module r2a_digit_array #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  r2a_pkg::ctrl_t                ctrl,
	input  logic                          bit_in,
	input  logic [r2a_pkg::BASE_W-1:0]    base,
	output logic [r2a_pkg::DIGIT_W-1:0]   top_digit
);

	localparam int unsigned DW = r2a_pkg::DIGIT_W;

	logic [DW-1:0]          digit_q [VALUE_WIDTH];
	logic [VALUE_WIDTH-1:0] carry_q;
	logic [VALUE_WIDTH-1:0] en_q;
	logic [VALUE_WIDTH-1:0] step_en;
	logic [VALUE_WIDTH-1:0] carry_in;

	assign step_en[0]  = ctrl.feed;
	assign carry_in[0] = bit_in;

	genvar i;
	generate
		for (i = 0; i < VALUE_WIDTH; i++) begin : g_cell
			logic [DW:0]   dbl;
			logic          cout;
			logic [DW-1:0] dnext;

			if (i > 0) begin : g_link
				// Cell i steps in the cycle after cell i-1, from its registered enable and carry.
				assign step_en[i]  = en_q[i-1];
				assign carry_in[i] = carry_q[i-1];
			end

			always_comb begin
				dbl   = {digit_q[i], 1'b0} + (DW+1)'(carry_in[i]);
				cout  = (dbl >= {1'b0, base});
				dnext = cout ? DW'(dbl - {1'b0, base}) : dbl[DW-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					en_q[i]    <= 1'b0;
					carry_q[i] <= 1'b0;
				end else if (ctrl.clear) begin
					en_q[i]    <= 1'b0;
					carry_q[i] <= 1'b0;
				end else begin
					en_q[i]    <= step_en[i];
					carry_q[i] <= step_en[i] & cout;
				end
			end

			always_ff @(posedge clk) begin
				if (ctrl.clear) begin
					digit_q[i] <= '0;
				end else if (ctrl.shift) begin
					if (i == 0)
						digit_q[i] <= '0;
					else
						digit_q[i] <= digit_q[(i > 0) ? i-1 : 0];
				end else if (step_en[i]) begin
					digit_q[i] <= dnext;
				end
			end
		end
	endgenerate

	assign top_digit = digit_q[VALUE_WIDTH-1];

endmodule

@@ rtl/radix_integer_to_ascii.sv @@
// Top level of the radix integer-to-ASCII converter (bases 2 to 36).
//
// Converts the low VALUE_WIDTH bits of an unsigned value to its digits in
// the requested base and sends them most significant first, one ASCII
// character per result ('0'-'9', then 'a'-'z'), with last set on the final
// digit. Zero gives the single digit '0'. A base outside 2 to 36 gives one
// result with invalid_base set, digit_char 0 and last set. Timing: a request
// is taken only when the converter is idle. In conversion, the value is fed
// one bit per cycle into a row of VALUE_WIDTH digit cells, each doubling its
// digit and adding the carry of the cell below, with the carry registered
// between cells so the step wave crosses the row diagonally. The digits then
// shift out of the top cell one per cycle while the result register is free,
// holding while the result side stalls; leading zero cells are dropped
// without producing a result. The result register lets the next request in
// while the final digit is still waiting to be taken.
module radix_integer_to_ascii #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	r2a_in_if.sink            req,
	r2a_out_if.source         rsp
);

	localparam int unsigned CW = $clog2(2*VALUE_WIDTH);
	localparam int unsigned PW = $clog2(VALUE_WIDTH);
	localparam logic [CW-1:0] FEED_END = CW'(VALUE_WIDTH);
	localparam logic [CW-1:0] CONV_END = CW'(2*VALUE_WIDTH-2);
	localparam logic [PW-1:0] POS_TOP  = PW'(VALUE_WIDTH-1);

	r2a_pkg::state_t state_q, state_nxt;
	r2a_pkg::ctrl_t  ctrl;

	logic [VALUE_WIDTH-1:0]         val_q;
	logic [r2a_pkg::BASE_W-1:0]     base_q;
	logic [CW-1:0]                  cnt_q;
	logic [PW-1:0]                  pos_q;
	logic                           started_q;
	logic [r2a_pkg::DIGIT_W-1:0]    top_digit;

	logic                           out_valid_q;
	logic [r2a_pkg::CHAR_W-1:0]     out_char_q;
	logic                           out_last_q;
	logic                           out_bad_q;

	logic base_ok;
	logic slot_free;
	logic accept;
	logic emit_dig;
	logic emit_bad;

	assign base_ok   = (req.base >= r2a_pkg::BASE_MIN) && (req.base <= r2a_pkg::BASE_MAX);
	assign slot_free = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			r2a_pkg::ST_IDLE: begin
				if (req.valid)
					state_nxt = base_ok ? r2a_pkg::ST_CONV : r2a_pkg::ST_BAD;
			end
			r2a_pkg::ST_CONV: begin
				if (cnt_q == CONV_END)
					state_nxt = r2a_pkg::ST_EMIT;
			end
			r2a_pkg::ST_EMIT: begin
				if (slot_free && pos_q == '0)
					state_nxt = r2a_pkg::ST_IDLE;
			end
			r2a_pkg::ST_BAD: begin
				if (slot_free)
					state_nxt = r2a_pkg::ST_IDLE;
			end
			default: state_nxt = r2a_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req.ready  = 1'b0;
		ctrl.clear = 1'b0;
		ctrl.feed  = 1'b0;
		ctrl.shift = 1'b0;
		emit_dig   = 1'b0;
		emit_bad   = 1'b0;
		unique case (state_q)
			r2a_pkg::ST_IDLE: begin
				req.ready  = 1'b1;
				ctrl.clear = req.valid;
			end
			r2a_pkg::ST_CONV: begin
				ctrl.feed = (cnt_q < FEED_END);
			end
			r2a_pkg::ST_EMIT: begin
				// Drop leading zeros; the lowest cell always produces a digit.
				ctrl.shift = slot_free;
				emit_dig   = slot_free && (started_q || top_digit != '0 || pos_q == '0);
			end
			r2a_pkg::ST_BAD: begin
				emit_bad = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= r2a_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// Value shift register, step counter and emit position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pos_q     <= '0;
			started_q <= 1'b0;
		end else begin
			if (accept)
				cnt_q <= '0;
			else if (state_q == r2a_pkg::ST_CONV)
				cnt_q <= cnt_q + CW'(1);

			if (state_q == r2a_pkg::ST_CONV && cnt_q == CONV_END) begin
				pos_q     <= POS_TOP;
				started_q <= 1'b0;
			end else if (ctrl.shift) begin
				pos_q     <= pos_q - PW'(1);
				started_q <= started_q | emit_dig;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= req.value[VALUE_WIDTH-1:0];
			base_q <= req.base;
		end else if (ctrl.feed) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	r2a_digit_array #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_array (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.bit_in    (val_q[VALUE_WIDTH-1]),
		.base      (base_q),
		.top_digit (top_digit)
	);

	// Result register: load a digit or the invalid flag, hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_dig || emit_bad)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_bad) begin
			out_char_q <= r2a_pkg::CHAR_NONE;
			out_last_q <= 1'b1;
			out_bad_q  <= 1'b1;
		end else if (emit_dig) begin
			out_char_q <= r2a_pkg::digit_char(top_digit);
			out_last_q <= (pos_q == '0);
			out_bad_q  <= 1'b0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.digit_char   = out_char_q;
	assign rsp.last         = out_last_q;
	assign rsp.invalid_base = out_bad_q;

endmodule

@@ verif/radix_integer_to_ascii_test.sv @@
// Self-checking testbench for radix_integer_to_ascii: directed and random requests, scoreboard.
`timescale 1ns / 100ps

typedef struct packed {
	logic [r2a_pkg::CHAR_W-1:0] ch;
	logic                       last;
	logic                       bad_base;
} digit_rec_t;

class digit_scoreboard;
	int unsigned value_width;
	string       digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
	digit_rec_t  pending_digits[$];
	int          mismatches;
	int          digits_checked;
	int          requests_seen;
	int          bad_requests;

	function new(int unsigned width);
		value_width    = width;
		mismatches     = 0;
		digits_checked = 0;
		requests_seen  = 0;
		bad_requests   = 0;
	endfunction

	// Work out the digit string of an accepted request and queue it.
	function void note_request(logic [63:0] value, logic [r2a_pkg::BASE_W-1:0] base);
		logic [63:0]                mask;
		logic [63:0]                rest;
		logic [r2a_pkg::CHAR_W-1:0] msd_first[$];
		digit_rec_t                 rec;
		requests_seen++;
		if (base < r2a_pkg::BASE_MIN || base > r2a_pkg::BASE_MAX) begin
			bad_requests++;
			rec.ch       = r2a_pkg::CHAR_NONE;
			rec.last     = 1'b1;
			rec.bad_base = 1'b1;
			pending_digits.push_back(rec);
			return;
		end
		mask = (value_width >= 64) ? '1 : ((64'd1 << value_width) - 64'd1);
		rest = value & mask;
		do begin
			msd_first.push_front(r2a_pkg::CHAR_W'(digit_set[int'(rest % 64'(base))]));
			rest = rest / 64'(base);
		end while (rest != 0 && msd_first.size() < value_width);
		foreach (msd_first[k]) begin
			rec.ch       = msd_first[k];
			rec.last     = (k == msd_first.size() - 1);
			rec.bad_base = 1'b0;
			pending_digits.push_back(rec);
		end
	endfunction

	// Compare one delivered digit with the oldest one expected.
	function void check_digit(logic [r2a_pkg::CHAR_W-1:0] ch, logic last, logic bad_base);
		digit_rec_t want;
		if (pending_digits.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] unexpected digit: char=%0d last=%0b invalid_base=%0b",
					$realtime, ch, last, bad_base);
			return;
		end
		want = pending_digits.pop_front();
		digits_checked++;
		if (ch !== want.ch || last !== want.last || bad_base !== want.bad_base) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"[%0t] digit mismatch: expected char=%0d last=%0b ",
					"invalid_base=%0b, got char=%0d last=%0b invalid_base=%0b"},
					$realtime, want.ch, want.last, want.bad_base, ch, last, bad_base);
		end
	endfunction
endclass

module radix_integer_to_ascii_test;

	localparam int unsigned VALUE_WIDTH = 64;
	localparam int unsigned DRAIN_CYCLES = 3 * VALUE_WIDTH + 32;
	localparam int unsigned RANDOM_REQUESTS = 80;
	localparam longint unsigned CYCLE_LIMIT = 1_000_000;

	logic clk;
	logic arst_n;
	// Suppress idling on both sides while set.
	logic steady;
	longint unsigned cycle_count;

	r2a_in_if  req ();
	r2a_out_if rsp ();

	digit_scoreboard digits_sb;

	radix_integer_to_ascii #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// Free-running clock, 12 ns period.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Known values on every input from time zero.
	initial begin
		arst_n    = 1'b0;
		steady    = 1'b0;
		req.valid = 1'b0;
		req.value = '0;
		req.base  = '0;
		rsp.ready = 1'b0;
		digits_sb = new(VALUE_WIDTH);
	end

	// Watchdog: end the run if the design hangs.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digits still expected",
				cycle_count, digits_sb.pending_digits.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: sample the handshake as it stood before the edge, then
	// pick the next cycle's ready. Stall with a chance of 38 in a hundred
	// unless the steady window is open.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			digits_sb.check_digit(rsp.digit_char, rsp.last, rsp.invalid_base);
		rsp.ready <= steady || ($urandom_range(0, 99) >= 38);
	end

	// Present one request and hold it until the converter takes it. Drop
	// valid only on idle cycles, so back-to-back requests keep valid high
	// without a second assignment in the same step.
	task automatic send_request(input logic [63:0] value,
		input logic [r2a_pkg::BASE_W-1:0] base);
		while (!steady && $urandom_range(0, 99) < 38) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.value <= value;
		req.base  <= base;
		do
			@(posedge clk);
		while (!req.ready);
		digits_sb.note_request(value, base);
	endtask

	initial begin
		logic [63:0]                rnd_value;
		logic [r2a_pkg::BASE_W-1:0] rnd_base;

		// Hold reset low from time zero, then release it on an edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: zero, the widest values, the smallest and largest
		// bases, single and two-digit edges, and bad bases on both sides.
		send_request(64'd0, 6'd10);
		send_request(64'd0, 6'd2);
		send_request('1, 6'd2);
		send_request('1, 6'd36);
		send_request('1, 6'd10);
		send_request('1, 6'd16);
		send_request('1, 6'd3);
		send_request(64'h8000_0000_0000_0000, 6'd2);
		send_request(64'd1, 6'd2);
		send_request(64'd35, 6'd36);
		send_request(64'd36, 6'd36);
		send_request(64'd9, 6'd10);
		send_request(64'd10, 6'd11);
		send_request(64'd255, 6'd16);
		send_request(64'd4096, 6'd8);
		send_request(64'd12345, 6'd0);
		send_request('1, 6'd1);
		send_request(64'd0, 6'd37);
		send_request('1, 6'd63);
		send_request(64'h0123_4567_89ab_cdef, 6'd7);

		// Random part: mostly valid bases with a mix of value sizes, plus a
		// stretch in the middle with no idling on either side.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			steady = (i >= 25 && i < 55);
			case ($urandom_range(0, 9))
				0:       rnd_value = '0;
				1:       rnd_value = '1;
				2, 3:    rnd_value = {$urandom, $urandom} >> $urandom_range(0, 63);
				4:       rnd_value = 64'($urandom_range(0, 40));
				default: rnd_value = {$urandom, $urandom};
			endcase
			if ($urandom_range(0, 99) < 12)
				rnd_base = $urandom_range(0, 1) ? 6'($urandom_range(0, 1))
					: 6'($urandom_range(37, 63));
			else
				rnd_base = 6'($urandom_range(2, 36));
			send_request(rnd_value, rnd_base);
		end
		steady = 1'b0;
		req.valid <= 1'b0;

		// Drain: wait for every expected digit, then watch for strays.
		while (digits_sb.pending_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d requests (%0d with a bad base) and checked %0d digits.",
			digits_sb.requests_seen, digits_sb.bad_requests, digits_sb.digits_checked);
		$display("Mismatched or unexpected digits: %0d, digits never delivered: %0d.",
			digits_sb.mismatches, digits_sb.pending_digits.size());
		if (digits_sb.mismatches == 0 && digits_sb.pending_digits.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/r2a_pkg.sv
rtl/r2a_in_if.sv
rtl/r2a_out_if.sv
rtl/r2a_digit_array.sv
rtl/radix_integer_to_ascii.sv
verif/radix_integer_to_ascii_test.sv
